>>> hw/rtl/ita_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_pkg
// shared types, sizes and character constants of the integer to ascii
// formatter: kind and radix codes, digit cell control, digit character table
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_WIDTH = 32;
  // one cell per digit; octal needs the most digits, ceil(width / 3)
  localparam int NUM_CELLS   = (VALUE_WIDTH + 2) / 3;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(NUM_CELLS + 1);

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    KIND_CHAR     = 3'd0,
    KIND_SIGNED   = 3'd1,
    KIND_UNSIGNED = 3'd2,
    KIND_OCTAL    = 3'd3,
    KIND_HEX      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREFIX0,
    ST_PREFIX1,
    ST_DIGITS
  } state_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic   clear;
    logic   conv;
    logic   shift;
    radix_t radix;
  } chain_ctrl_t;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  localparam logic [7:0] HEX_TABLE [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // digit value at which doubling overflows the radix
  function automatic digit_t radix_half(radix_t r);
    digit_t h;
    unique case (r)
      RADIX_DEC: h = 4'd5;
      RADIX_OCT: h = 4'd4;
      RADIX_HEX: h = 4'd8;
      default:   h = 4'd8;
    endcase
    return h;
  endfunction

  function automatic logic [4:0] radix_value(radix_t r);
    logic [4:0] v;
    unique case (r)
      RADIX_DEC: v = 5'd10;
      RADIX_OCT: v = 5'd8;
      RADIX_HEX: v = 5'd16;
      default:   v = 5'd16;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/ita_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_cell
// one digit of the conversion row: doubles its digit plus the carry from
// below each convert cycle, or takes the lower digit when shifting out
// ----------------------------------------------------------------------------
module ita_cell (
  input  logic                clk,
  input  ita_pkg::chain_ctrl_t ctrl,
  input  logic                cin,
  input  ita_pkg::digit_t     din,
  output logic                cout,
  output ita_pkg::digit_t     digit
);
  import ita_pkg::*;

  logic [4:0] dbl;
  logic [4:0] adj;
  logic       carry;

  // carry depends on the stored digit only, so nothing ripples along the row
  always_comb begin
    dbl   = {digit, cin};
    carry = (digit >= radix_half(ctrl.radix));
    adj   = carry ? (dbl - radix_value(ctrl.radix)) : dbl;
  end

  assign cout = carry;

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= adj[3:0];
    end else if (ctrl.shift) begin
      digit <= din;
    end
  end

endmodule

>>> hw/rtl/ita_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_chain
// row of digit cells, least significant first; takes the value one bit a
// cycle at the bottom and shifts digits out at the top
// ----------------------------------------------------------------------------
module ita_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  ita_pkg::chain_ctrl_t ctrl,
  input  logic                 serial_in,
  output ita_pkg::digit_t      top_digit
);
  import ita_pkg::*;

  logic   carry [NUM_CELLS+1];
  digit_t link  [NUM_CELLS+1];

  assign carry[0] = serial_in;
  assign link[0]  = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    ita_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cin   (carry[i]),
      .din   (link[i]),
      .cout  (carry[i+1]),
      .digit (link[i+1])
    );
  end

  assign top_digit = link[NUM_CELLS];

  // the magnitude always fits the row, so the top cell never carries out
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.conv |-> !carry[NUM_CELLS])
    else $error("digit row overflow");

endmodule

>>> hw/rtl/integer_to_ascii_radix_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_formatter
// prints one value per word as ascii characters: character pass-through,
// signed or unsigned decimal, octal, or hex with a 0x prefix
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload            notes
//  --------  -----------------  -----------------  ---------------------------
//  input     start & !busy      kind, value        one word per accept
//  output    strobe (1 cycle)   character, last    last marks final character
//
// sequence: a character pass-through word gives its result on the next cycle
//   and busy stays low. every other word keeps busy high through the convert
//   steps (one value bit per cycle into the cell row), then up to two prefix
//   characters, then the digit steps that shift the row out at the top; the
//   final character strobes in the same cycle that busy drops.
// reset: rst is synchronous; it clears the state machine and the strobe.
// stalls: the receiver cannot stall, results go out as they are made;
//   start is ignored while busy, and unused kinds are dropped with no result.
//
module integer_to_ascii_radix_formatter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      kind,
  input  logic [ita_pkg::VALUE_WIDTH-1:0] value,
  output logic                            strobe,
  output logic [7:0]                      character,
  output logic                            last
);
  import ita_pkg::*;

  state_t                 state, state_next;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;
  logic                   seen;
  logic                   neg;
  logic                   hex;
  radix_t                 radix;

  logic                   accept;
  logic                   go;
  logic                   in_neg;
  radix_t                 in_radix;
  chain_ctrl_t            ctrl;
  digit_t                 top_digit;

  logic                   emit;
  logic [7:0]             char_next;
  logic                   last_next;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign in_neg = (kind == KIND_SIGNED) && value[VALUE_WIDTH-1];

  // decode the kind of an incoming word
  always_comb begin
    go       = 1'b0;
    in_radix = RADIX_DEC;
    unique case (kind)
      KIND_SIGNED, KIND_UNSIGNED: begin
        go = 1'b1;
      end
      KIND_OCTAL: begin
        go       = 1'b1;
        in_radix = RADIX_OCT;
      end
      KIND_HEX: begin
        go       = 1'b1;
        in_radix = RADIX_HEX;
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  // next state and outputs
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    char_next   = CHAR_ZERO;
    last_next   = 1'b0;
    ctrl.clear  = accept;
    ctrl.conv   = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.radix  = radix;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_CHAR) begin
            emit      = 1'b1;
            char_next = value[7:0];
            last_next = 1'b1;
          end else if (go) begin
            state_next = ST_CONVERT;
          end
        end
      end
      ST_CONVERT: begin
        ctrl.conv = 1'b1;
        if (bit_cnt == '0) begin
          state_next = (neg || hex) ? ST_PREFIX0 : ST_DIGITS;
        end
      end
      ST_PREFIX0: begin
        emit       = 1'b1;
        char_next  = neg ? CHAR_MINUS : CHAR_ZERO;
        state_next = hex ? ST_PREFIX1 : ST_DIGITS;
      end
      ST_PREFIX1: begin
        emit       = 1'b1;
        char_next  = CHAR_X;
        state_next = ST_DIGITS;
      end
      ST_DIGITS: begin
        ctrl.shift = 1'b1;
        // leading zeros are skipped, but the lowest digit always prints
        if (seen || (top_digit != '0) || (dig_cnt == DIG_CNT_W'(1))) begin
          emit      = 1'b1;
          char_next = HEX_TABLE[top_digit & NIBBLE_MASK];
          last_next = (dig_cnt == DIG_CNT_W'(1));
        end
        if (dig_cnt == DIG_CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  // word registers, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      // the most negative value negates to itself, which is its magnitude
      mag     <= in_neg ? (~value + VALUE_WIDTH'(1)) : value;
      bit_cnt <= BIT_CNT_W'(VALUE_WIDTH - 1);
      dig_cnt <= DIG_CNT_W'(NUM_CELLS);
      seen    <= 1'b0;
      neg     <= in_neg;
      hex     <= (kind == KIND_HEX);
      radix   <= in_radix;
    end else begin
      if (state == ST_CONVERT) begin
        mag     <= {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      end
      if (state == ST_DIGITS) begin
        dig_cnt <= dig_cnt - DIG_CNT_W'(1);
        if (emit) begin
          seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= char_next;
      last      <= last_next;
    end
  end

  ita_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .serial_in (mag[VALUE_WIDTH-1]),
    .top_digit (top_digit)
  );

  // a character word out while idle is always the final one of its word
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && strobe) |-> last)
    else $error("non-final character after word finished");

  // more characters follow a non-final one, so the block is still working
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final character while idle");

  // pass-through answers on the next cycle with a single final character
  a_char_pass: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_CHAR) |=> (strobe && last && !busy))
    else $error("pass-through character missing");

endmodule

>>> tb/tb_integer_to_ascii_radix_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_formatter
// self-checking bench for the integer to ascii formatter: every accepted word
// is turned into its expected character string by an independent predictor,
// and each strobed character is checked in order against that string;
// directed corner words come first, then bursts of random words with random
// gaps, with periodic full drains of the output
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_formatter;
  import ita_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 6;
  localparam int STALL_LIMIT = 2000;
  // margin for the tail of the longest word
  localparam int DRAIN_CYC   = 60;
  localparam int RANDOM_WORDS = 280;

  localparam logic [2:0] KIND_TOP = '1;
  localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] MOST_POS = ~MOST_NEG;
  localparam string DIGIT_CHARS = "0123456789abcdef";

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [2:0]             kind;
  logic [VALUE_WIDTH-1:0] value;
  logic                   strobe;
  logic [7:0]             character;
  logic                   last;

  text_char_t  expected_text [$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned ignored_words;
  int unsigned chars_checked;
  int unsigned quiet_cycles;

  integer_to_ascii_radix_formatter DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // expected text of one word, appended to the queue of pending characters
  function automatic void predict_text(logic [2:0] k, logic [VALUE_WIDTH-1:0] v);
    logic [7:0]             text [$];
    logic [7:0]             digits [$];
    logic [VALUE_WIDTH-1:0] mag;
    int unsigned            base;
    mag  = v;
    base = 0;
    case (k)
      KIND_CHAR:     text.push_back(v[7:0]);
      KIND_SIGNED: begin
        // two's complement magnitude; the most negative value stays exact as unsigned
        if (v[VALUE_WIDTH-1]) begin
          text.push_back(CHAR_MINUS);
          mag = -v;
        end
        base = 10;
      end
      KIND_UNSIGNED: base = 10;
      KIND_OCTAL:    base = 8;
      KIND_HEX: begin
        text.push_back(CHAR_ZERO);
        text.push_back(CHAR_X);
        base = 16;
      end
      default: ignored_words++;
    endcase
    if (base != 0) begin
      // zero still gives one digit
      do begin
        digits.push_front(DIGIT_CHARS[mag % base]);
        mag = mag / base;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    foreach (text[i]) expected_text.push_back('{text[i], i == text.size() - 1});
  endfunction

  // result checker and word predictor, both on the pre-edge values
  always @(posedge clk) begin
    text_char_t exp_ch;
    if (!rst) begin
      if (strobe) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          $error("unexpected character %h (last %b) with nothing pending", character, last);
          error_count++;
        end else begin
          exp_ch = expected_text.pop_front();
          if (character !== exp_ch.ch) begin
            $error("character mismatch: expected %h, actual %h", exp_ch.ch, character);
            error_count++;
          end
          if (last !== exp_ch.is_last) begin
            $error("last mismatch: expected %b, actual %b", exp_ch.is_last, last);
            error_count++;
          end
        end
      end
      if (start && !busy) predict_text(kind, value);
    end
  end

  // watchdog on cycles with neither an accepted word nor a strobe
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // offer one word and hold it until an edge where busy is low; start stays up
  task automatic send_word(input logic [2:0] k, input logic [VALUE_WIDTH-1:0] v);
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // sender gap with junk on the data lines; zero length means no idling at all
  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      kind  <= 3'($urandom);
      value <= $urandom;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold off until every pending character has come out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  task automatic test_char_passthrough();
    send_word(KIND_CHAR, '0);
    send_word(KIND_CHAR, VALUE_WIDTH'(8'hff));
    // high bits must not leak into the character
    send_word(KIND_CHAR, ALL_ONES ^ VALUE_WIDTH'(8'hbe));
  endtask

  task automatic test_decimal_corners();
    send_word(KIND_SIGNED, '0);
    send_word(KIND_SIGNED, 1);
    send_word(KIND_SIGNED, ALL_ONES);
    send_word(KIND_SIGNED, MOST_POS);
    send_word(KIND_SIGNED, MOST_NEG);
    send_word(KIND_UNSIGNED, '0);
    send_word(KIND_UNSIGNED, ALL_ONES);
    send_word(KIND_UNSIGNED, 1000000000);
  endtask

  task automatic test_octal_hex_corners();
    send_word(KIND_OCTAL, '0);
    send_word(KIND_OCTAL, ALL_ONES);
    send_word(KIND_OCTAL, 8);
    send_word(KIND_HEX, '0);
    send_word(KIND_HEX, ALL_ONES);
    send_word(KIND_HEX, 32'h0000abcd);
  endtask

  task automatic test_unused_kinds();
    logic [2:0] k;
    for (k = 3'(KIND_HEX + 1); k != KIND_CHAR; k++) send_word(k, $urandom);
    // the dropped words must not disturb a following one
    send_word(KIND_HEX, MOST_NEG);
    wait_drained();
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(1, VALUE_WIDTH - 1);
      2: v = $urandom_range(0, 20);
      3: v = -$urandom_range(1, 20);
      default: v = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
    endcase
    return v;
  endfunction

  task automatic test_random_mix(input int unsigned target);
    int unsigned done;
    int unsigned next_drain;
    int unsigned burst;
    logic [2:0]  k;
    done       = 0;
    next_drain = 60;
    while (done < target) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        // a few dropped kinds as noise, not counted
        if ($urandom_range(0, 15) == 0) begin
          k = 3'($urandom_range(KIND_HEX + 1, KIND_TOP));
        end else begin
          k = 3'($urandom_range(KIND_CHAR, KIND_HEX));
          done++;
        end
        send_word(k, random_value());
      end
      if (done >= next_drain) begin
        wait_drained();
        next_drain += 60;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_gap(0);
      end else begin
        idle_gap($urandom_range(1, 50));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    kind          = '0;
    value         = '0;
    error_count   = 0;
    words_sent    = 0;
    ignored_words = 0;
    chars_checked = 0;
    quiet_cycles  = 0;
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_char_passthrough();
    test_decimal_corners();
    test_octal_hex_corners();
    test_unused_kinds();
    test_random_mix(RANDOM_WORDS);

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d words over all eight kind codes, %0d of them dropped kinds",
             words_sent, ignored_words);
    $display("checked %0d characters incl. sign, prefix and zero corners", chars_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ita_pkg.sv
hw/rtl/ita_cell.sv
hw/rtl/ita_chain.sv
hw/rtl/integer_to_ascii_radix_formatter.sv
tb/tb_integer_to_ascii_radix_formatter.sv
